FILE: hw/rtl/fbpm_pkg.sv
package fbpm_pkg;

  localparam int IDX_W  = 4;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 21;
  localparam int CFG_W  = 32;

  localparam logic [1:0] REQ_PRODUCE = 2'd0;
  localparam logic [1:0] REQ_GET     = 2'd1;
  localparam logic [1:0] REQ_RETURN  = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EMPTY     = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_NOT_OUT   = 2'd3;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_STRIDE = 1'b1;

  localparam logic [ADDR_W-1:0] BASE_RESET   = 32'd0;
  localparam logic [SIZE_W-1:0] STRIDE_RESET = 21'd65536;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] buffer_address;
    logic [SIZE_W-1:0] written_size;
  } fbpm_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  buffer_index;
    logic [ADDR_W-1:0] buffer_start;
    logic [SIZE_W-1:0] frame_len;
    logic              reused_filled;
  } fbpm_rsp_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } fbpm_scan_t;

endpackage

FILE: hw/rtl/fbpm_fifo.sv
module fbpm_fifo import fbpm_pkg::*; #(
  parameter int DEPTH  = 4,
  parameter bit PRESET = 1'b0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [IDX_W-1:0] push_data,
  input  logic             pop,
  output logic [IDX_W-1:0] head,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] mem_q;
  logic             sel_q;
  logic [PTR_W-1:0] ptr_q;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] wr_flag_r;
  logic             push_ok;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // a pop in the same cycle makes room for the push
  assign push_ok = push && ((count_r != CNT_W'(DEPTH)) || pop);

  always_comb begin
    rd_ptr_nxt = pop     ? ptr_next(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = push_ok ? ptr_next(wr_ptr_r) : wr_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      count_r   <= PRESET ? CNT_W'(DEPTH) : '0;
      wr_flag_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (push_ok) begin
        wr_flag_r[wr_ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= push_data;
    end
    mem_q <= mem[rd_ptr_r];
    sel_q <= wr_flag_r[rd_ptr_r] || !PRESET;
    ptr_q <= rd_ptr_r;
  end

  // with PRESET set, an entry never written holds its own position
  assign head  = sel_q ? mem_q : IDX_W'(ptr_q);
  assign count = count_r;

endmodule

FILE: hw/rtl/fbpm_scan.sv
module fbpm_scan import fbpm_pkg::*; #(
  parameter int NUM_BUFFERS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] base,
  input  logic [SIZE_W-1:0] stride,
  input  logic [ADDR_W-1:0] addr,
  output fbpm_scan_t        res
);

  localparam int CNT_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  logic              busy_r;
  logic [CNT_W-1:0]  pos_r;
  logic [ADDR_W-1:0] cand_r;
  logic              match;
  logic              last;

  assign match = (cand_r == addr);
  assign last  = (pos_r == CNT_W'(NUM_BUFFERS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (match || last)) begin
      busy_r <= 1'b0;
    end
  end

  // walk the buffer starts from index zero so the lowest index wins
  always_ff @(posedge clk) begin
    if (start) begin
      pos_r  <= '0;
      cand_r <= base;
    end else if (busy_r && !match && !last) begin
      pos_r  <= pos_r + CNT_W'(1);
      cand_r <= cand_r + ADDR_W'(stride);
    end
  end

  assign res.done  = busy_r && (match || last);
  assign res.found = busy_r && match;
  assign res.index = IDX_W'(pos_r);

endmodule

FILE: hw/rtl/frame_buffer_pool_manager_core.sv
// Frame buffer pool with drop-oldest policy. Each request gives exactly one
// response. Produce and get choose the buffer from the FIFO heads and then load
// the result into the response register; a return first scans the buffer starts
// up to the matched index, or through all NUM_BUFFERS starts when none matches.
// The start compare runs through one adder a cycle. A new request is taken in the
// cycle after the previous response is loaded into the output register, even
// while that response is still stalled; a stalled response holds the next one in
// its final step.
// Buffer state lives in two small FIFO memories and a size memory; no
// clearing pass is needed after reset.
module frame_buffer_pool_manager_core import fbpm_pkg::*; #(
  parameter int NUM_BUFFERS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fbpm_req_t        in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fbpm_rsp_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int BI_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam int PRD_W = IDX_W + SIZE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] stride_r;
  logic [NUM_BUFFERS-1:0] out_flag_r;

  fbpm_req_t req_r;

  logic [1:0]        status_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PRD_W-1:0]  prod_r;
  logic [SIZE_W-1:0] fsize_r;
  logic              reused_r;
  logic              use_calc_r;
  logic              use_addr_r;
  logic              size_from_mem_r;

  logic              out_valid_r;
  fbpm_rsp_t         out_data_r;

  logic [SIZE_W-1:0] size_mem [NUM_BUFFERS];
  logic [SIZE_W-1:0] size_q;

  logic             free_pop, free_push;
  logic             filled_pop, filled_push;
  logic [IDX_W-1:0] free_head, filled_head;
  logic [CNT_W-1:0] free_cnt, filled_cnt;

  logic             scan_start;
  fbpm_scan_t       scan_res;

  logic              accept;
  logic              fin_go;
  logic [SIZE_W-1:0] clamp_size;
  logic              have_buf;
  logic [IDX_W-1:0]  run_idx;
  logic              hit_out;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign clamp_size = (req_r.written_size > stride_r) ? stride_r : req_r.written_size;
  assign hit_out    = out_flag_r[scan_res.index[BI_W-1:0]];

  fbpm_fifo #(.DEPTH(NUM_BUFFERS), .PRESET(1'b1)) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (free_push),
    .push_data (scan_res.index),
    .pop       (free_pop),
    .head      (free_head),
    .count     (free_cnt)
  );

  fbpm_fifo #(.DEPTH(NUM_BUFFERS), .PRESET(1'b0)) u_filled (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (filled_push),
    .push_data (run_idx),
    .pop       (filled_pop),
    .head      (filled_head),
    .count     (filled_cnt)
  );

  fbpm_scan #(.NUM_BUFFERS(NUM_BUFFERS)) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .base   (base_r),
    .stride (stride_r),
    .addr   (req_r.buffer_address),
    .res    (scan_res)
  );

  // choose the buffer for produce or get from the FIFO heads read last cycle
  always_comb begin
    free_pop    = 1'b0;
    filled_pop  = 1'b0;
    filled_push = 1'b0;
    have_buf    = 1'b0;
    run_idx     = free_head;
    scan_start  = 1'b0;
    if (state_r == S_RUN) begin
      case (req_r.req_type)
        REQ_PRODUCE: begin
          if (free_cnt != '0) begin
            free_pop = 1'b1;
            have_buf = 1'b1;
          end else if (filled_cnt != '0) begin
            filled_pop = 1'b1;
            run_idx    = filled_head;
            have_buf   = 1'b1;
          end
          filled_push = have_buf;
        end
        REQ_GET: begin
          run_idx = filled_head;
          if (filled_cnt != '0) begin
            filled_pop = 1'b1;
            have_buf   = 1'b1;
          end
        end
        REQ_RETURN: begin
          scan_start = 1'b1;
        end
        default: begin
          have_buf = 1'b0;
        end
      endcase
    end
    free_push = (state_r == S_SCAN) && scan_res.found && hit_out;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_RUN;
      S_RUN:  state_nxt = (req_r.req_type == REQ_RETURN) ? S_SCAN : S_FIN;
      S_SCAN: if (scan_res.done) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      stride_r    <= STRIDE_RESET;
      out_flag_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:   base_r   <= cfg_wdata;
          CFG_STRIDE: stride_r <= cfg_wdata[SIZE_W-1:0];
          default:    base_r   <= base_r;
        endcase
      end
      if ((state_r == S_RUN) && (req_r.req_type == REQ_GET) && have_buf) begin
        out_flag_r[run_idx[BI_W-1:0]] <= 1'b1;
      end
      if (free_push) begin
        out_flag_r[scan_res.index[BI_W-1:0]] <= 1'b0;
      end
    end
  end

  // size memory: produce writes, get reads at the same step
  always_ff @(posedge clk) begin
    if ((state_r == S_RUN) && (req_r.req_type == REQ_PRODUCE) && have_buf) begin
      size_mem[run_idx[BI_W-1:0]] <= clamp_size;
    end
    if ((state_r == S_RUN) && (req_r.req_type == REQ_GET)) begin
      size_q <= size_mem[run_idx[BI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (state_r == S_RUN) begin
      status_r        <= have_buf ? STS_OK : STS_EMPTY;
      idx_r           <= have_buf ? run_idx : '0;
      prod_r          <= PRD_W'(run_idx) * PRD_W'(stride_r);
      use_calc_r      <= have_buf;
      use_addr_r      <= 1'b0;
      reused_r        <= have_buf && (req_r.req_type == REQ_PRODUCE) && (free_cnt == '0);
      fsize_r         <= (have_buf && (req_r.req_type == REQ_PRODUCE)) ? clamp_size : '0;
      size_from_mem_r <= have_buf && (req_r.req_type == REQ_GET);
    end
    if ((state_r == S_SCAN) && scan_res.done) begin
      use_addr_r <= scan_res.found;
      idx_r      <= scan_res.found ? scan_res.index : '0;
      if (!scan_res.found) begin
        status_r <= STS_NOT_FOUND;
      end else if (hit_out) begin
        status_r <= STS_OK;
      end else begin
        status_r <= STS_NOT_OUT;
      end
    end
    if (fin_go) begin
      out_data_r.status        <= status_r;
      out_data_r.buffer_index  <= idx_r;
      out_data_r.reused_filled <= reused_r;
      out_data_r.frame_len     <= size_from_mem_r ? size_q : fsize_r;
      if (use_addr_r) begin
        out_data_r.buffer_start <= req_r.buffer_address;
      end else if (use_calc_r) begin
        out_data_r.buffer_start <= base_r + ADDR_W'(prod_r);
      end else begin
        out_data_r.buffer_start <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/testbench.sv
module testbench;
  import fbpm_pkg::*;

  localparam int POOL_SIZE = 4;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  fbpm_req_t        in_data;
  logic             out_valid;
  logic             out_stall;
  fbpm_rsp_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int holdoff_left = 0;

  class pool_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] stride;
    logic [IDX_W-1:0]  free_q[$];
    logic [IDX_W-1:0]  filled_q[$];
    logic [15:0]       out_flags;
    logic [SIZE_W-1:0] sizes[16];
    fbpm_rsp_t         pending_rsp[$];
    int n_errors;
    int n_checked;
    int n_reused;
    int n_by_status[4];

    function new();
      base = BASE_RESET;
      stride = STRIDE_RESET;
      out_flags = '0;
      n_errors = 0;
      n_checked = 0;
      n_reused = 0;
      for (int i = 0; i < 16; i++) sizes[i] = '0;
      for (int i = 0; i < 4; i++) n_by_status[i] = 0;
      for (int i = 0; i < POOL_SIZE; i++) free_q.push_back(IDX_W'(i));
    endfunction

    function logic [ADDR_W-1:0] start_of(int idx);
      return base + ADDR_W'(idx) * ADDR_W'(stride);
    endfunction

    // random checked-out buffer, or -1 when none is out
    function int pick_checked_out();
      int cands[$];
      for (int i = 0; i < POOL_SIZE; i++)
        if (out_flags[i]) cands.push_back(i);
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(cands.size() - 1)];
    endfunction

    function void note_request(fbpm_req_t r);
      fbpm_rsp_t        rsp;
      logic [IDX_W-1:0] idx;
      bit               have;
      bit               found;
      rsp = '0;
      rsp.status = STS_EMPTY;
      idx = '0;
      case (r.req_type)
        REQ_PRODUCE: begin
          have = 1'b1;
          if (free_q.size() > 0) begin
            idx = free_q.pop_front();
          end else if (filled_q.size() > 0) begin
            idx = filled_q.pop_front();
            rsp.reused_filled = 1'b1;
          end else begin
            have = 1'b0;
          end
          if (have) begin
            sizes[idx] = (r.written_size > stride) ? stride : r.written_size;
            filled_q.push_back(idx);
            rsp.status = STS_OK;
            rsp.buffer_index = idx;
            rsp.buffer_start = start_of(idx);
            rsp.frame_len = sizes[idx];
          end
        end
        REQ_GET: begin
          if (filled_q.size() > 0) begin
            idx = filled_q.pop_front();
            out_flags[idx] = 1'b1;
            rsp.status = STS_OK;
            rsp.buffer_index = idx;
            rsp.buffer_start = start_of(idx);
            rsp.frame_len = sizes[idx];
          end
        end
        REQ_RETURN: begin
          rsp.status = STS_NOT_FOUND;
          found = 1'b0;
          // lowest matching index wins when starts coincide
          for (int i = 0; i < POOL_SIZE; i++) begin
            if (!found && start_of(i) == r.buffer_address) begin
              found = 1'b1;
              rsp.buffer_index = IDX_W'(i);
              rsp.buffer_start = r.buffer_address;
              if (out_flags[i]) begin
                out_flags[i] = 1'b0;
                if (free_q.size() < POOL_SIZE) free_q.push_back(IDX_W'(i));
                rsp.status = STS_OK;
              end else begin
                rsp.status = STS_NOT_OUT;
              end
            end
          end
        end
        default: ;
      endcase
      n_by_status[rsp.status]++;
      if (rsp.reused_filled) n_reused++;
      pending_rsp.push_back(rsp);
    endfunction

    function void report_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_response(fbpm_rsp_t got);
      fbpm_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %0h", $time, got);
        n_errors++;
        return;
      end
      want = pending_rsp.pop_front();
      n_checked++;
      report_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
      report_field("buffer_index", ADDR_W'(want.buffer_index), ADDR_W'(got.buffer_index));
      report_field("buffer_start", want.buffer_start, got.buffer_start);
      report_field("frame_len", ADDR_W'(want.frame_len), ADDR_W'(got.frame_len));
      report_field("reused_filled", ADDR_W'(want.reused_filled), ADDR_W'(got.reused_filled));
    endfunction
  endclass

  pool_scoreboard sb;

  frame_buffer_pool_manager_core #(
    .NUM_BUFFERS(POOL_SIZE)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // receiver: random stalls, quiet stretches and a long hold-off on demand
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= !out_quiet && ($urandom_range(99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
  end

  function automatic fbpm_req_t make_request(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                             logic [SIZE_W-1:0] size);
    fbpm_req_t r;
    r.req_type = kind;
    r.buffer_address = addr;
    r.written_size = size;
    return r;
  endfunction

  function automatic fbpm_req_t random_request(int ret_pct);
    fbpm_req_t r;
    int        roll;
    int        idx;
    r.buffer_address = $urandom();
    case ($urandom_range(9))
      0:       r.written_size = '0;
      1:       r.written_size = '1;
      2:       r.written_size = sb.stride;
      3:       r.written_size = sb.stride + 1'b1;
      4, 5:    r.written_size = SIZE_W'($urandom_range(4096));
      default: r.written_size = SIZE_W'($urandom());
    endcase
    roll = $urandom_range(99);
    if (roll < 5) begin
      r.req_type = 2'd3;
    end else if (roll < 5 + ret_pct) begin
      r.req_type = REQ_RETURN;
      idx = sb.pick_checked_out();
      roll = $urandom_range(99);
      // mostly hand back a buffer that is out; otherwise any start, a near miss or a random address
      if (idx >= 0 && roll < 70) r.buffer_address = sb.start_of(idx);
      else if (roll < 85) r.buffer_address = sb.start_of($urandom_range(POOL_SIZE - 1));
      else if (roll < 93) r.buffer_address = sb.start_of($urandom_range(POOL_SIZE - 1)) + 1;
    end else begin
      r.req_type = ($urandom_range(99) < 55) ? REQ_PRODUCE : REQ_GET;
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(fbpm_req_t r);
    int gap;
    if (!in_quiet && $urandom_range(99) < 17) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic return_buffer(int idx);
    send_request(make_request(REQ_RETURN, sb.start_of(idx), '0));
  endtask

  task automatic wait_for_responses();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    // returns scan one start a cycle; let the slowest one settle
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] stride);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    sb.base = base;
    @(negedge clk);
    cfg_index <= CFG_STRIDE;
    cfg_wdata <= CFG_W'(stride);
    @(posedge clk);
    sb.stride = stride;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, int ret_pct);
    repeat (count) send_request(random_request(ret_pct));
  endtask

  initial begin
    int held;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE;
    cfg_wdata = '0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pool edges, clamping, reclaim, drop, bad returns
    send_request(make_request(REQ_GET, '0, '0));
    send_request(make_request(REQ_RETURN, '0, '0));
    send_request(make_request(REQ_RETURN, 32'h0001_2345, '0));
    send_request(make_request(2'd3, '1, '1));
    send_request(make_request(REQ_PRODUCE, '0, '0));
    send_request(make_request(REQ_PRODUCE, '0, '1));
    send_request(make_request(REQ_PRODUCE, '0, STRIDE_RESET));
    send_request(make_request(REQ_PRODUCE, '0, STRIDE_RESET + 1'b1));
    send_request(make_request(REQ_PRODUCE, '0, 21'd100));
    send_request(make_request(REQ_GET, '0, '0));
    send_request(make_request(REQ_GET, '0, '0));
    held = sb.pick_checked_out();
    return_buffer(held);
    return_buffer(held);
    send_request(make_request(REQ_RETURN, '1, '0));
    repeat (3) send_request(make_request(REQ_GET, '0, '0));
    send_request(make_request(REQ_PRODUCE, '0, 21'd500));
    send_request(make_request(REQ_GET, '0, '0));
    send_request(make_request(REQ_PRODUCE, '0, 21'd7));
    for (int i = 0; i < POOL_SIZE; i++) return_buffer(i);
    wait_for_responses();

    // stride of 2^20, quiet start then random idling
    configure_pool(32'h1000_0000, 21'd1048576);
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    run_random(150, 28);
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    run_random(250, 28);
    wait_for_responses();

    // stride of one, starts wrap past the top of memory
    configure_pool('1, 21'd1);
    run_random(300, 12);
    wait_for_responses();

    // random setting; hold the receiver off so the block backs up
    configure_pool($urandom(), SIZE_W'($urandom_range(1, 1048576)));
    holdoff_left = 400;
    run_random(300, 28);
    wait_for_responses();

    // zero stride: every buffer shares the base address
    configure_pool(32'hDEAD_BEEF, '0);
    run_random(150, 28);
    wait_for_responses();

    configure_pool(32'hA5A5_5A5A, '1);
    run_random(200, 40);
    wait_for_responses();

    if (sb.pending_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived, expected 0, actual %0d", $time,
               sb.pending_rsp.size(), sb.pending_rsp.size());
      sb.n_errors++;
    end
    $display("Checked %0d responses over six pool settings: %0d ok, %0d empty or dropped,",
             sb.n_checked, sb.n_by_status[STS_OK], sb.n_by_status[STS_EMPTY]);
    $display("%0d unknown address, %0d not checked out, %0d filled frames reclaimed.",
             sb.n_by_status[STS_NOT_FOUND], sb.n_by_status[STS_NOT_OUT], sb.n_reused);
    if (sb.n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
